// ----- rtl/lcdns_pkg.sv -----
// ----------------------------------------------------------------------------
// lcdns_pkg
// Types and constants shared by the character LCD nibble sender.
// ----------------------------------------------------------------------------
`default_nettype none

package lcdns_pkg;

  localparam int BYTE_W   = 8;
  localparam int NIB_W    = 4;
  localparam int HOLD_W   = 8;
  localparam int LEVEL_W  = 5;
  localparam int CMD_W    = 2;
  localparam int INIT_LEN = 5;
  localparam int INIT_IW  = 3;

  localparam logic [HOLD_W-1:0] HOLD_RESET = 8'd1;
  localparam logic [HOLD_W-1:0] WAIT_MAX   = 8'hFF;

  // input command codes; code 3 is unused
  typedef enum logic [CMD_W-1:0] {
    CMD_TICK = 2'd0,
    CMD_PUSH = 2'd1,
    CMD_INIT = 2'd2
  } cmd_t;

  typedef enum logic [3:0] {
    PH_HIGH        = 4'b0001,
    PH_LOW         = 4'b0010,
    PH_WAIT_BEFORE = 4'b0100,
    PH_WAIT_HOLD   = 4'b1000
  } phase_t;

  // queue entry: command flag over the byte
  typedef struct packed {
    logic              is_cmd;
    logic [BYTE_W-1:0] value;
  } entry_t;

  typedef struct packed {
    logic push;
    logic pop;
    logic init;
  } q_op_t;

  typedef struct packed {
    logic   nonempty;
    logic   full;
    entry_t head;
  } q_stat_t;

  typedef struct packed {
    logic             rs;
    logic             en;
    logic [NIB_W-1:0] data;
  } pins_t;

  // start-up command bytes, in queue order
  function automatic logic [BYTE_W-1:0] init_byte(input logic [INIT_IW-1:0] idx);
    logic [BYTE_W-1:0] b;
    case (idx)
      3'd0:    b = 8'h02;
      3'd1:    b = 8'h28;
      3'd2:    b = 8'h08;
      3'd3:    b = 8'h0F;
      3'd4:    b = 8'h01;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/lcdns_in_if.sv -----
// ----------------------------------------------------------------------------
// lcdns_in_if
// Input channel: tick, push or init beats.
// ----------------------------------------------------------------------------
`default_nettype none

interface lcdns_in_if import lcdns_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [BYTE_W-1:0] byte_value;
  logic              is_command;

  modport source (output valid, output command, output byte_value, output is_command,
                  input ready);
  modport sink   (input valid, input command, input byte_value, input is_command,
                  output ready);
endinterface

`default_nettype wire

// ----- rtl/lcdns_out_if.sv -----
// ----------------------------------------------------------------------------
// lcdns_out_if
// Result channel: pin levels and queue status after each beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface lcdns_out_if import lcdns_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               rs_pin;
  logic               en_pin;
  logic [NIB_W-1:0]   data_nibble;
  logic               busy_res;
  logic [LEVEL_W-1:0] queue_level;
  logic               dropped;

  modport source (output valid, output rs_pin, output en_pin, output data_nibble,
                  output busy_res, output queue_level, output dropped, input ready);
  modport sink   (input valid, input rs_pin, input en_pin, input data_nibble,
                  input busy_res, input queue_level, input dropped, output ready);
endinterface

`default_nettype wire

// ----- rtl/lcdns_cfg_if.sv -----
// ----------------------------------------------------------------------------
// lcdns_cfg_if
// Configuration write channel for the hold_ticks register.
// ----------------------------------------------------------------------------
`default_nettype none

interface lcdns_cfg_if import lcdns_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [HOLD_W-1:0] hold_ticks;

  modport source (output valid, output hold_ticks, input ready);
  modport sink   (input valid, input hold_ticks, output ready);
endinterface

`default_nettype wire

// ----- rtl/char_lcd_nibble_sender_core.sv -----
// ----------------------------------------------------------------------------
// char_lcd_nibble_sender_core
// Character LCD byte sender for the 4-bit bus: byte queue plus nibble sequencer.
// ----------------------------------------------------------------------------
//  port    dir  handshake      beat contents
//  in_ch   in   valid/ready    command, byte_value, is_command
//  out_ch  out  valid/ready    rs_pin, en_pin, data_nibble, busy_res, queue_level,
//                              dropped
//  cfg_ch  in   valid/ready    hold_ticks (always ready)
//
//  One beat per cycle sustained while the output takes results; a result is
//  offered once its input beat has passed the input register and then the
//  state/result registers. The queue RAM read is issued ahead, from rp_nxt,
//  with write forwarding, so the head entry is ready for the very next beat.
//  Output stalls hold the input stage; input is still taken while the stage
//  empties into a free or draining result register.
//  Reset empties the queue, idles the sequencer with EN high, hold_ticks = 1.
// ----------------------------------------------------------------------------
`default_nettype none

module char_lcd_nibble_sender_core import lcdns_pkg::*; #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  lcdns_in_if.sink    in_ch,
  lcdns_out_if.source out_ch,
  lcdns_cfg_if.sink   cfg_ch
);

  localparam int FW = $clog2(QUEUE_DEPTH+1);

  logic              in_v_r;
  logic [CMD_W-1:0]  in_cmd_r;
  entry_t            in_entry_r;
  logic              out_v_r;
  logic              dropped_r;
  logic [HOLD_W-1:0] hold_r;

  logic              advance;
  logic              do_tick;
  logic              do_push;
  logic              do_init;
  q_op_t             q_op;
  q_stat_t           q_stat;
  logic [FW-1:0]     level;
  logic              pop;
  pins_t             pins;
  logic              busy;

  assign advance     = in_v_r && (!out_v_r || out_ch.ready);
  assign in_ch.ready = !in_v_r || advance;
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
      hold_r  <= HOLD_RESET;
    end else begin
      if (in_ch.ready) begin
        in_v_r <= in_ch.valid;
      end
      if (advance) begin
        out_v_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_v_r <= 1'b0;
      end
      if (cfg_ch.valid) begin
        hold_r <= cfg_ch.hold_ticks;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      in_cmd_r          <= in_ch.command;
      in_entry_r.value  <= in_ch.byte_value;
      in_entry_r.is_cmd <= in_ch.is_command;
    end
    if (advance) begin
      dropped_r <= do_push && q_stat.full;
    end
  end

  always_comb begin
    do_tick = 1'b0;
    do_push = 1'b0;
    do_init = 1'b0;
    unique case (in_cmd_r)
      CMD_TICK: do_tick = advance;
      CMD_PUSH: do_push = advance;
      CMD_INIT: do_init = advance;
      default:  ;
    endcase
  end

  assign q_op.push = do_push;
  assign q_op.pop  = pop;
  assign q_op.init = do_init;

  lcdns_queue #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .op         (q_op),
    .push_entry (in_entry_r),
    .stat       (q_stat),
    .level      (level)
  );

  lcdns_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .tick  (do_tick),
    .init  (do_init),
    .hold  (hold_r),
    .qs    (q_stat),
    .pop   (pop),
    .pins  (pins),
    .busy  (busy)
  );

  // sequencer and queue state only move on advance, so they double as the
  // result register
  assign out_ch.valid       = out_v_r;
  assign out_ch.rs_pin      = pins.rs;
  assign out_ch.en_pin      = pins.en;
  assign out_ch.data_nibble = pins.data;
  assign out_ch.busy_res    = busy;
  assign out_ch.queue_level = LEVEL_W'(level);
  assign out_ch.dropped     = dropped_r;

  a_advance_out: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_v_r)
    else $error("advanced beat produced no result");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (in_v_r && out_v_r && !out_ch.ready) |=> in_v_r && $stable(in_cmd_r))
    else $error("input stage lost a beat under stall");

  a_drop_push: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && !(do_push && q_stat.full)) |=> !dropped_r)
    else $error("dropped flag set without a full push");

endmodule

`default_nettype wire

// ----- rtl/lcdns_ram.sv -----
// ----------------------------------------------------------------------------
// lcdns_ram
// Generic single-write, single-read RAM with registered read (read-first).
// ----------------------------------------------------------------------------
`default_nettype none

module lcdns_ram #(
  parameter int WIDTH = 9,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- rtl/lcdns_queue.sv -----
// ----------------------------------------------------------------------------
// lcdns_queue
// Ring queue of command/data bytes with a head entry ready every cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module lcdns_queue import lcdns_pkg::*; #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  q_op_t                              op,
  input  entry_t                             push_entry,
  output q_stat_t                            stat,
  output logic [$clog2(QUEUE_DEPTH+1)-1:0]   level
);

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int FW = $clog2(QUEUE_DEPTH+1);

  logic [AW-1:0]       wp_r, wp_nxt;
  logic [AW-1:0]       rp_r, rp_nxt;
  logic [FW-1:0]       fill_r, fill_nxt;
  // start-up entries live in constants until a push overwrites their slot
  logic [INIT_LEN-1:0] cv_r, cv_nxt;
  logic                we;
  logic                full;
  logic                cst_hit;

  logic                byp_r;
  logic                cst_r;
  entry_t              wd_r;
  logic [INIT_IW-1:0]  cidx_r;
  entry_t              rd_data;
  entry_t              head;

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    return (p == AW'(QUEUE_DEPTH-1)) ? '0 : p + 1'b1;
  endfunction

  assign full = (fill_r == FW'(QUEUE_DEPTH));

  always_comb begin
    wp_nxt   = wp_r;
    rp_nxt   = rp_r;
    fill_nxt = fill_r;
    cv_nxt   = cv_r;
    we       = 1'b0;
    cst_hit  = 1'b0;
    if (op.init) begin
      wp_nxt   = AW'(INIT_LEN);
      rp_nxt   = '0;
      fill_nxt = FW'(INIT_LEN);
      cv_nxt   = '1;
    end else if (op.push && !full) begin
      we       = 1'b1;
      wp_nxt   = ptr_inc(wp_r);
      fill_nxt = fill_r + 1'b1;
      for (int i = 0; i < INIT_LEN; i++) begin
        if (wp_r == AW'(i)) cv_nxt[i] = 1'b0;
      end
    end else if (op.pop) begin
      rp_nxt   = ptr_inc(rp_r);
      fill_nxt = fill_r - 1'b1;
    end
    for (int i = 0; i < INIT_LEN; i++) begin
      if (rp_nxt == AW'(i) && cv_nxt[i]) cst_hit = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r   <= '0;
      rp_r   <= '0;
      fill_r <= '0;
      cv_r   <= '0;
      byp_r  <= 1'b0;
      cst_r  <= 1'b0;
    end else begin
      wp_r   <= wp_nxt;
      rp_r   <= rp_nxt;
      fill_r <= fill_nxt;
      cv_r   <= cv_nxt;
      // RAM reads old data when written and read at the same address
      byp_r  <= we && (wp_r == rp_nxt);
      cst_r  <= cst_hit;
    end
  end

  always_ff @(posedge clk) begin
    wd_r   <= push_entry;
    cidx_r <= rp_nxt[INIT_IW-1:0];
  end

  lcdns_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (wp_r),
    .wdata (push_entry),
    .raddr (rp_nxt),
    .rdata (rd_data)
  );

  always_comb begin
    if (byp_r) begin
      head = wd_r;
    end else if (cst_r) begin
      head = '{is_cmd: 1'b1, value: init_byte(cidx_r)};
    end else begin
      head = rd_data;
    end
  end

  assign stat.nonempty = (fill_r != '0);
  assign stat.full     = full;
  assign stat.head     = head;
  assign level         = fill_r;

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FW'(QUEUE_DEPTH))
    else $error("queue fill count above depth");

  a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
    (fill_r == '0) |-> (wp_r == rp_r))
    else $error("empty queue with pointers apart");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (op.pop && !op.init) |-> (fill_r != '0))
    else $error("pop from empty queue");

endmodule

`default_nettype wire

// ----- rtl/lcdns_seq.sv -----
// ----------------------------------------------------------------------------
// lcdns_seq
// Nibble sequencer: places RS and data, waits, pulses EN low per nibble.
// ----------------------------------------------------------------------------
`default_nettype none

module lcdns_seq import lcdns_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              tick,
  input  logic              init,
  input  logic [HOLD_W-1:0] hold,
  input  q_stat_t           qs,
  output logic              pop,
  output pins_t             pins,
  output logic              busy
);

  phase_t            phase_r, phase_nxt;
  logic              after_low_r, after_low_nxt;
  logic [HOLD_W-1:0] wait_r, wait_nxt;
  pins_t             pins_r, pins_nxt;
  logic [HOLD_W-1:0] wait_inc;
  logic              wait_done;

  // saturating count; a hold of zero is met on the first tick
  assign wait_inc  = (wait_r == WAIT_MAX) ? WAIT_MAX : wait_r + 1'b1;
  assign wait_done = (wait_inc >= hold);

  always_comb begin
    phase_nxt     = phase_r;
    after_low_nxt = after_low_r;
    wait_nxt      = wait_r;
    pins_nxt      = pins_r;
    pop           = 1'b0;
    if (init) begin
      phase_nxt     = PH_HIGH;
      after_low_nxt = 1'b1;
      wait_nxt      = '0;
      pins_nxt.rs   = 1'b0;
      pins_nxt.en   = 1'b1;
    end else if (tick) begin
      unique case (phase_r)
        PH_HIGH: begin
          if (qs.nonempty) begin
            pins_nxt.rs   = ~qs.head.is_cmd;
            pins_nxt.data = qs.head.value[BYTE_W-1:NIB_W];
            after_low_nxt = 1'b1;
            phase_nxt     = PH_WAIT_BEFORE;
            wait_nxt      = '0;
          end
        end
        PH_LOW: begin
          if (!qs.nonempty) begin
            phase_nxt = PH_HIGH;
          end else begin
            pins_nxt.data = qs.head.value[NIB_W-1:0];
            pop           = 1'b1;
            after_low_nxt = 1'b0;
            phase_nxt     = PH_WAIT_BEFORE;
            wait_nxt      = '0;
          end
        end
        PH_WAIT_BEFORE: begin
          wait_nxt = wait_inc;
          if (wait_done) begin
            pins_nxt.en = 1'b0;
            phase_nxt   = PH_WAIT_HOLD;
            wait_nxt    = '0;
          end
        end
        PH_WAIT_HOLD: begin
          wait_nxt = wait_inc;
          if (wait_done) begin
            pins_nxt.en = 1'b1;
            phase_nxt   = after_low_r ? PH_LOW : PH_HIGH;
          end
        end
        default: begin
          phase_nxt = PH_HIGH;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HIGH;
      after_low_r <= 1'b1;
      wait_r      <= '0;
      pins_r      <= '{rs: 1'b0, en: 1'b1, data: '0};
    end else begin
      phase_r     <= phase_nxt;
      after_low_r <= after_low_nxt;
      wait_r      <= wait_nxt;
      pins_r      <= pins_nxt;
    end
  end

  assign pins = pins_r;
  assign busy = (phase_r != PH_HIGH);

  a_en_low_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !pins_r.en |-> (phase_r == PH_WAIT_HOLD))
    else $error("EN low outside hold phase");

  a_init_idle: assert property (@(posedge clk) disable iff (!rst_n)
    init |=> (phase_r == PH_HIGH) && pins_r.en && !pins_r.rs && (wait_r == '0))
    else $error("init did not return sequencer to idle");

  a_pop_low: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> (phase_r == PH_WAIT_BEFORE) && !after_low_r)
    else $error("low nibble pop without pulse setup");

endmodule

`default_nettype wire

// ----- test/tb_char_lcd_nibble_sender_core.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_char_lcd_nibble_sender_core
// Self-checking bench for the character LCD nibble sender. A scoreboard
// class models the byte queue and the nibble sequencer and predicts the pins
// and queue status after every input beat. Inputs come from directed
// sequences, then from random push/tick streams under several hold_ticks
// settings, with random idle bursts on both channels and one long output
// stall that backs the block up.
// ----------------------------------------------------------------------------

module tb_char_lcd_nibble_sender_core import lcdns_pkg::*;;

  localparam int QDEPTH = 16;
  localparam int CYCLE_LIMIT = 400000;
  localparam int LONG_STALL = 250;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam logic [BYTE_W-1:0] START_SEQ [INIT_LEN] = '{8'h02, 8'h28, 8'h08, 8'h0F, 8'h01};

  typedef struct packed {
    pins_t              pins;
    logic               busy;
    logic [LEVEL_W-1:0] level;
    logic               dropped;
  } sender_out_t;

  class lcd_sender_sb;
    entry_t      ring [QDEPTH];
    int          wr_ix, rd_ix, fill;
    phase_t      seq_ph, next_ph;
    logic [7:0]  wait_cnt, hold;
    pins_t       pins;
    sender_out_t want_q [$];
    int          n_beats, n_pushes, n_drops, n_inits, n_checked, n_err;

    function new();
      foreach (ring[i]) ring[i] = '0;
      wr_ix = 0;
      rd_ix = 0;
      fill = 0;
      seq_ph = PH_HIGH;
      next_ph = PH_LOW;
      wait_cnt = 8'd0;
      hold = HOLD_RESET;
      pins = '{rs: 1'b0, en: 1'b1, data: 4'h0};
    endfunction

    function void set_hold(logic [7:0] v);
      hold = v;
    endfunction

    function int pending();
      return want_q.size();
    endfunction

    function bit enqueue(logic [7:0] v, logic c);
      if (fill >= QDEPTH) return 1'b0;
      ring[wr_ix] = '{is_cmd: c, value: v};
      wr_ix = (wr_ix + 1) % QDEPTH;
      fill++;
      return 1'b1;
    endfunction

    // counter saturates; a hold of zero behaves like one
    function bit count_up();
      if (wait_cnt != WAIT_MAX) wait_cnt++;
      return wait_cnt >= hold;
    endfunction

    function void advance();
      entry_t e;
      e = ring[rd_ix];
      case (seq_ph)
        PH_HIGH: begin
          if (fill != 0) begin
            pins.rs = ~e.is_cmd;
            pins.data = e.value[7:4];
            next_ph = PH_LOW;
            seq_ph = PH_WAIT_BEFORE;
            wait_cnt = 8'd0;
          end
        end
        PH_LOW: begin
          if (fill == 0) begin
            seq_ph = PH_HIGH;
          end else begin
            pins.data = e.value[3:0];
            rd_ix = (rd_ix + 1) % QDEPTH;
            fill--;
            next_ph = PH_HIGH;
            seq_ph = PH_WAIT_BEFORE;
            wait_cnt = 8'd0;
          end
        end
        PH_WAIT_BEFORE: begin
          if (count_up()) begin
            pins.en = 1'b0;
            seq_ph = PH_WAIT_HOLD;
            wait_cnt = 8'd0;
          end
        end
        default: begin
          if (count_up()) begin
            pins.en = 1'b1;
            seq_ph = next_ph;
          end
        end
      endcase
    endfunction

    function void note_beat(logic [CMD_W-1:0] c, logic [7:0] b, logic ic);
      sender_out_t r;
      logic lost;
      lost = 1'b0;
      n_beats++;
      case (c)
        CMD_TICK: advance();
        CMD_PUSH: begin
          n_pushes++;
          if (!enqueue(b, ic)) begin
            lost = 1'b1;
            n_drops++;
          end
        end
        CMD_INIT: begin
          // abandons any transfer; data pins keep their levels
          n_inits++;
          wr_ix = 0;
          rd_ix = 0;
          fill = 0;
          seq_ph = PH_HIGH;
          next_ph = PH_LOW;
          wait_cnt = 8'd0;
          pins.rs = 1'b0;
          pins.en = 1'b1;
          foreach (START_SEQ[i]) void'(enqueue(START_SEQ[i], 1'b1));
        end
        default: ;
      endcase
      r.pins = pins;
      r.busy = (seq_ph != PH_HIGH);
      r.level = LEVEL_W'(fill);
      r.dropped = lost;
      want_q.push_back(r);
    endfunction

    function void compare(string field, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        n_err++;
        if (n_err <= 10)
          $display("%0t: %s mismatch on result %0d: expected %0h, got %0h",
                   $realtime, field, n_checked, want, got);
      end
    endfunction

    function void check_result(sender_out_t got);
      sender_out_t want;
      if (want_q.size() == 0) begin
        n_err++;
        if (n_err <= 10) $display("%0t: result beat with nothing expected", $realtime);
        return;
      end
      want = want_q.pop_front();
      compare("rs_pin", 8'(want.pins.rs), 8'(got.pins.rs));
      compare("en_pin", 8'(want.pins.en), 8'(got.pins.en));
      compare("data_nibble", 8'(want.pins.data), 8'(got.pins.data));
      compare("busy_res", 8'(want.busy), 8'(got.busy));
      compare("queue_level", 8'(want.level), 8'(got.level));
      compare("dropped", 8'(want.dropped), 8'(got.dropped));
      n_checked++;
    endfunction
  endclass

  logic clk;
  logic rst_n;
  bit   quiet;
  bit   long_stall_req;
  bit   long_stall_done;
  int   cycles;

  lcd_sender_sb sb = new();

  lcdns_in_if  in_ch ();
  lcdns_out_if out_ch ();
  lcdns_cfg_if cfg_ch ();

  char_lcd_nibble_sender_core #(.QUEUE_DEPTH(QDEPTH)) uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still due", cycles, sb.pending());
      $display("[char_lcd_nibble_sender_core] ERROR");
      $finish;
    end
  end

  // result side: checks every beat, stalls in random bursts and once for long
  initial begin : result_sink
    int stall_left;
    sender_out_t got;
    stall_left = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        got.pins.rs = out_ch.rs_pin;
        got.pins.en = out_ch.en_pin;
        got.pins.data = out_ch.data_nibble;
        got.busy = out_ch.busy_res;
        got.level = out_ch.queue_level;
        got.dropped = out_ch.dropped;
        sb.check_result(got);
      end
      if (!rst_n) begin
        out_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= (stall_left == 0);
      end else if (long_stall_req && !long_stall_done) begin
        long_stall_done = 1'b1;
        stall_left = LONG_STALL;
        out_ch.ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 11) == 0) begin
        stall_left = $urandom_range(1, 17);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  task automatic send_beat(input logic [CMD_W-1:0] c, input logic [7:0] b, input logic ic);
    int gap;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 17);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.command <= c;
    in_ch.byte_value <= b;
    in_ch.is_command <= ic;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_beat(c, b, ic);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_hold(input logic [7:0] v);
    drain();
    cfg_ch.valid <= 1'b1;
    cfg_ch.hold_ticks <= v;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    sb.set_hold(v);
  endtask

  // mostly pushes and ticks with random content; inits and code 3 as noise
  task automatic random_beats(input int count, input int push_pct);
    int r;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < 3)
        send_beat(CMD_INIT, 8'($urandom), 1'($urandom));
      else if (r < 5)
        send_beat(CMD_UNUSED, 8'($urandom), 1'($urandom));
      else if (r < 5 + push_pct)
        send_beat(CMD_PUSH, 8'($urandom), 1'($urandom));
      else
        send_beat(CMD_TICK, 8'($urandom), 1'($urandom));
    end
  endtask

  initial begin : stimulus
    rst_n = 1'b0;
    quiet = 1'b0;
    long_stall_req = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.command = CMD_TICK;
    in_ch.byte_value = 8'h00;
    in_ch.is_command = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.hold_ticks = HOLD_RESET;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty tick, init cut short by another init, fill to full,
    // dropped push, unused code, one full byte out
    send_beat(CMD_TICK, 8'hFF, 1'b1);
    send_beat(CMD_INIT, 8'h00, 1'b0);
    repeat (3) send_beat(CMD_TICK, 8'h00, 1'b0);
    send_beat(CMD_INIT, 8'hFF, 1'b1);
    send_beat(CMD_PUSH, 8'h00, 1'b1);
    send_beat(CMD_PUSH, 8'hFF, 1'b0);
    repeat (9) send_beat(CMD_PUSH, 8'($urandom), 1'($urandom));
    send_beat(CMD_PUSH, 8'hA5, 1'b0);
    send_beat(CMD_UNUSED, 8'h5A, 1'b1);
    repeat (6) send_beat(CMD_TICK, 8'($urandom), 1'($urandom));
    send_beat(CMD_PUSH, 8'h3C, 1'b0);

    // longest hold: one EN pulse on the high nibble, then init mid-byte
    write_hold(8'hFF);
    send_beat(CMD_PUSH, 8'hC3, 1'b0);
    repeat (520) send_beat(CMD_TICK, 8'($urandom), 1'($urandom));
    send_beat(CMD_INIT, 8'($urandom), 1'($urandom));

    write_hold(8'h00);
    random_beats(50, 30);
    write_hold(8'h01);
    long_stall_req = 1'b1;
    random_beats(60, 35);
    write_hold(8'h02);
    random_beats(50, 25);
    write_hold(8'($urandom_range(3, 20)));
    random_beats(50, 15);

    // closing stretch with no idle bursts
    write_hold(8'h03);
    quiet = 1'b1;
    random_beats(50, 30);

    drain();
    repeat (8) @(posedge clk);
    $display("%0d beats sent: %0d pushes (%0d dropped), %0d inits; %0d results checked",
             sb.n_beats, sb.n_pushes, sb.n_drops, sb.n_inits, sb.n_checked);
    $display("hold_ticks settings 0, 1, 2, 3, 255 and one random; %0d mismatches",
             sb.n_err);
    if (sb.n_err == 0)
      $display("[char_lcd_nibble_sender_core] OK");
    else
      $display("[char_lcd_nibble_sender_core] ERROR");
    $finish;
  end

endmodule
